FILE: rtl/core/poly_coeff_compress_pack_assert.svh
// assertion macros for the coefficient compress and pack block
`ifndef POLY_COEFF_COMPRESS_PACK_ASSERT_SVH
`define POLY_COEFF_COMPRESS_PACK_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCCP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pccp assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define PCCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pccp assertion failed");

`endif

FILE: rtl/core/pccp_pkg.sv
// package with widths and constants of the coefficient compress and pack block
package pccp_pkg;

    localparam int COEFF_W = 13;
    localparam int U_W = 12;
    localparam int BYTE_W = 8;
    localparam int CFG_W = 3;
    localparam int T_W = 6;
    localparam int X_W = 18;
    localparam int PROD_W = 36;
    localparam int Q_W = 7;
    localparam int LEFT_W = 7;
    localparam int CNT_W = 3;
    localparam int SUM_W = 4;
    localparam int ACC_W = 13;

    localparam int DEFAULT_COEFFS = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;
    localparam logic [CFG_W-1:0] D_MIN = 3'd3;
    localparam logic [CFG_W-1:0] D_MAX = 3'd6;

    localparam logic signed [COEFF_W-1:0] COEFF_HI = 13'sd3328;
    localparam logic signed [COEFF_W-1:0] COEFF_LO = -13'sd3328;
    localparam logic [COEFF_W-1:0] MODULUS_Q = 13'd3329;
    localparam logic [X_W-1:0] HALF_Q = 18'd1664;

    // floor(x / 3329) == (x * RECIP_M) >> RECIP_SH for every x below 2^21
    localparam logic [X_W-1:0] RECIP_M = 18'd161271;
    localparam int RECIP_SH = 29;

endpackage

FILE: rtl/core/pccp_if.sv
// valid/ready channel interfaces for coefficient words and packed byte words
interface pccp_coeff_if
    import pccp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink (input valid, input coefficient, output ready);
endinterface

interface pccp_byte_if
    import pccp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              last_byte;

    modport source (output valid, output packed_byte, output last_byte, input ready);
    modport sink (input valid, input packed_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/poly_coeff_compress_pack.sv
// top level: compresses signed coefficients to d bits and packs them into bytes
//
// coeff_in carries one signed 13-bit coefficient per word (valid/ready);
// byte_out carries packed bytes, least significant bit first, with
// last_byte set on the final byte of each polynomial of COEFFS_PER_POLY
// coefficients. cfg_we/cfg_data write the bits per coefficient (3..6,
// values outside act as the nearest end); write only while idle.
// a coefficient is held in the input register, is clamped, compressed
// with one 18x18 reciprocal multiply and packed into the pending bits or
// the output register as it advances: a word that fills a byte passes through
// the input register and then the output register, which holds the byte valid until it is taken.
// one word per cycle is sustained while byte_out is ready; words that
// complete no byte never wait for the output register.
// if the receiver stalls, the output register holds its byte and the input
// register keeps taking words until it holds one that completes a byte,
// then ready drops.
// reset clears the pending bits, the coefficient index and both valid
// flags, and sets the width to 4 bits.
module poly_coeff_compress_pack
    import pccp_pkg::*;
#(
    parameter int COEFFS_PER_POLY = DEFAULT_COEFFS
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    pccp_coeff_if.sink       coeff_in,
    pccp_byte_if.source      byte_out
);

    localparam int IDX_W = $clog2(COEFFS_PER_POLY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COEFFS_PER_POLY - 1);

    logic [CFG_W-1:0]          cfg_bits_reg;
    logic                      s1_valid_reg;
    logic signed [COEFF_W-1:0] coeff_reg;
    logic [LEFT_W-1:0]         left_bits_reg;
    logic [CNT_W-1:0]          left_cnt_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      out_valid_reg;
    logic [BYTE_W-1:0]         out_byte_reg;
    logic                      out_last_reg;

    logic [CFG_W-1:0]          d_act;
    logic signed [COEFF_W-1:0] coeff_sat;
    logic [COEFF_W-1:0]        coeff_mod;
    logic [U_W-1:0]            u_val;
    logic [X_W-1:0]            x_val;
    logic [PROD_W-1:0]         prod;
    logic [Q_W-1:0]            q_val;
    logic [T_W-1:0]            t_mask;
    logic [T_W-1:0]            t_val;
    logic [ACC_W-1:0]          acc;
    logic [SUM_W-1:0]          cnt_sum;
    logic                      is_last;
    logic                      produce;
    logic                      advance;
    logic                      in_ready;
    logic [LEFT_W-1:0]         left_bits_next;
    logic [CNT_W-1:0]          left_cnt_next;
    logic [IDX_W-1:0]          idx_next;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bits_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_bits_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (cfg_bits_reg < D_MIN)
        begin
            d_act = D_MIN;
        end
        else if (cfg_bits_reg > D_MAX)
        begin
            d_act = D_MAX;
        end
        else
        begin
            d_act = cfg_bits_reg;
        end
    end

    // clamp, fold negatives, compress
    always_comb
    begin
        if (coeff_reg > COEFF_HI)
        begin
            coeff_sat = COEFF_HI;
        end
        else if (coeff_reg < COEFF_LO)
        begin
            coeff_sat = COEFF_LO;
        end
        else
        begin
            coeff_sat = coeff_reg;
        end
        coeff_mod = coeff_sat[COEFF_W-1] ? (unsigned'(coeff_sat) + MODULUS_Q)
                                         : unsigned'(coeff_sat);
        u_val  = coeff_mod[U_W-1:0];
        x_val  = (X_W'(u_val) << d_act) + HALF_Q;
        prod   = PROD_W'(x_val) * PROD_W'(RECIP_M);
        q_val  = prod[PROD_W-1:RECIP_SH];
        t_mask = T_W'((Q_W'(1) << d_act) - Q_W'(1));
        t_val  = q_val[T_W-1:0] & t_mask;
    end

    // bit packing
    always_comb
    begin
        acc     = ACC_W'(left_bits_reg) | (ACC_W'(t_val) << left_cnt_reg);
        cnt_sum = SUM_W'(left_cnt_reg) + SUM_W'(d_act);
        is_last = (idx_reg >= IDX_LAST);
        if (is_last)
        begin
            produce        = (cnt_sum != '0);
            left_bits_next = '0;
            left_cnt_next  = '0;
            idx_next       = '0;
        end
        else if (cnt_sum >= SUM_W'(BYTE_W))
        begin
            produce        = 1'b1;
            left_bits_next = LEFT_W'(acc[ACC_W-1:BYTE_W]);
            left_cnt_next  = CNT_W'(cnt_sum - SUM_W'(BYTE_W));
            idx_next       = idx_reg + IDX_W'(1);
        end
        else
        begin
            produce        = 1'b0;
            left_bits_next = acc[LEFT_W-1:0];
            left_cnt_next  = cnt_sum[CNT_W-1:0];
            idx_next       = idx_reg + IDX_W'(1);
        end
    end

    assign advance = s1_valid_reg && (!produce || !out_valid_reg || byte_out.ready);
    assign in_ready = !s1_valid_reg || advance;

    assign coeff_in.ready       = in_ready;
    assign byte_out.valid       = out_valid_reg;
    assign byte_out.packed_byte = out_byte_reg;
    assign byte_out.last_byte   = out_last_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            left_bits_reg <= '0;
            left_cnt_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= coeff_in.valid;
            end
            if (advance)
            begin
                left_bits_reg <= left_bits_next;
                left_cnt_reg  <= left_cnt_next;
                idx_reg       <= idx_next;
            end
            if (advance && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (byte_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && coeff_in.valid)
        begin
            coeff_reg <= coeff_in.coefficient;
        end
        if (advance && produce)
        begin
            out_byte_reg <= acc[BYTE_W-1:0];
            out_last_reg <= is_last;
        end
    end

`include "poly_coeff_compress_pack_assert.svh"

    `PCCP_ASSERT_NEXT(a_clear_after_last, advance && is_last, (left_cnt_reg == '0) && (idx_reg == '0))
    `PCCP_ASSERT_NEXT(a_idx_step, advance && !is_last, idx_reg == ($past(idx_reg) + IDX_W'(1)))
    `PCCP_ASSERT_SAME(a_ready_when_empty, !s1_valid_reg, coeff_in.ready)
    `PCCP_ASSERT_NEXT(a_hold_when_blocked, s1_valid_reg && !advance, s1_valid_reg && $stable(coeff_reg))

endmodule

FILE: verif/poly_coeff_compress_pack_tb.sv
// testbench for poly_coeff_compress_pack: random coefficient stream checked against a bit-exact packer model
module poly_coeff_compress_pack_tb;
    import pccp_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int COEFFS = DEFAULT_COEFFS;
    localparam int TARGET_COEFFS = 1550;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_IDLE = 10;
    localparam int MAX_REPORTS = 50;

    localparam logic signed [COEFF_W-1:0] EDGE_COEFFS [17] = '{
        13'sd0, 13'sd1, -13'sd1, 13'sd3328, -13'sd3328, 13'sd3329, -13'sd3329,
        13'sd4095, 13'sh1000, 13'sd1664, 13'sd1665, -13'sd1664, -13'sd1665,
        13'sd104, 13'sd105, 13'sh0AAA, 13'sh1555
    };

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_byte;
    } byte_word_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    pccp_coeff_if coeff_ch ();
    pccp_byte_if  byte_ch ();

    poly_coeff_compress_pack #(
        .COEFFS_PER_POLY(COEFFS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .coeff_in(coeff_ch),
        .byte_out(byte_ch)
    );

    byte_word_t        expected_bytes[$];
    logic [CFG_W-1:0]  width_reg;
    logic [LEFT_W-1:0] pend_bits;
    int unsigned       pend_cnt;
    int unsigned       coeff_pos;
    bit                no_gaps;
    bit [7:0]          widths_seen;
    int                errors = 0;
    int                coeffs_sent = 0;
    int                bytes_checked = 0;
    int                polys_done = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned eff_width();
        if (width_reg < D_MIN)
        begin
            return 32'(D_MIN);
        end
        if (width_reg > D_MAX)
        begin
            return 32'(D_MAX);
        end
        return 32'(width_reg);
    endfunction

    function automatic int unsigned compress_coeff(input logic signed [COEFF_W-1:0] c,
                                                   input int unsigned d);
        int v;
        int unsigned u;
        v = int'(c);
        if (v > COEFF_HI)
        begin
            v = int'(COEFF_HI);
        end
        if (v < COEFF_LO)
        begin
            v = int'(COEFF_LO);
        end
        if (v < 0)
        begin
            v = v + int'(MODULUS_Q);
        end
        u = v;
        return (((u << d) + int'(HALF_Q)) / int'(MODULUS_Q)) & ((1 << d) - 1);
    endfunction

    // packs one coefficient into the pending bits and queues any finished byte
    function automatic void pack_coeff(input logic signed [COEFF_W-1:0] c);
        int unsigned d;
        int unsigned t;
        int unsigned acc;
        int unsigned cnt;
        byte_word_t  next_byte;
        d = eff_width();
        t = compress_coeff(c, d);
        acc = pend_bits | (t << pend_cnt);
        cnt = pend_cnt + d;
        coeffs_sent++;
        if (coeff_pos >= COEFFS - 1)
        begin
            // end of polynomial: pad or drop, then start over
            next_byte.packed_byte = acc[BYTE_W-1:0];
            next_byte.last_byte = 1'b1;
            expected_bytes.push_back(next_byte);
            pend_bits = '0;
            pend_cnt = 0;
            coeff_pos = 0;
            polys_done++;
        end
        else
        begin
            coeff_pos++;
            if (cnt >= BYTE_W)
            begin
                next_byte.packed_byte = acc[BYTE_W-1:0];
                next_byte.last_byte = 1'b0;
                expected_bytes.push_back(next_byte);
                pend_bits = acc[BYTE_W +: LEFT_W];
                pend_cnt = cnt - BYTE_W;
            end
            else
            begin
                pend_bits = acc[LEFT_W-1:0];
                pend_cnt = cnt;
            end
        end
    endfunction

    function automatic logic signed [COEFF_W-1:0] rand_coeff();
        int unsigned d;
        int unsigned u;
        d = eff_width();
        case ($urandom_range(0, 9))
            0: return COEFF_W'($urandom_range(0, (1 << COEFF_W) - 1));
            1: return EDGE_COEFFS[$urandom_range(0, 16)];
            2:
            begin
                // straddle a rounding step of the current width
                u = (($urandom_range(1, 1 << d) * int'(MODULUS_Q) - int'(HALF_Q)) >> d)
                    + $urandom_range(0, 1);
                if (u > COEFF_HI)
                begin
                    u = int'(COEFF_HI);
                end
                if (u > 0 && $urandom_range(0, 1) == 1)
                begin
                    return COEFF_W'(int'(u) - int'(MODULUS_Q));
                end
                return COEFF_W'(u);
            end
            default: return COEFF_W'(int'($urandom_range(0, 6656)) - 3328);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    task automatic send_coeff(input logic signed [COEFF_W-1:0] c);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            coeff_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coeff_ch.valid <= 1'b1;
        coeff_ch.coefficient <= c;
        do
            @(posedge clk);
        while (!coeff_ch.ready);
        pack_coeff(c);
    endtask

    task automatic wait_idle();
        coeff_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = value;
        widths_seen[value] = 1'b1;
    endtask

    task automatic test_extremes();
        foreach (EDGE_COEFFS[i])
        begin
            send_coeff(EDGE_COEFFS[i]);
        end
    endtask

    task automatic test_width_sweep();
        for (int w = 0; w < 8; w++)
        begin
            set_width(CFG_W'(w));
            repeat (24) send_coeff(rand_coeff());
        end
    endtask

    // steer the last two coefficients so the final byte drops bits or is padded
    task automatic finish_poly(input bit drop_bits);
        while (coeff_pos != COEFFS - 2)
        begin
            send_coeff(rand_coeff());
        end
        if (drop_bits)
        begin
            set_width(pend_cnt <= 4 ? D_MIN : D_MAX);
            send_coeff(rand_coeff());
            set_width(3'd7);
        end
        else
        begin
            set_width((pend_cnt <= 1 || pend_cnt >= 5) ? D_MIN : D_MAX);
            send_coeff(rand_coeff());
            set_width(3'd0);
        end
        send_coeff(rand_coeff());
    endtask

    task automatic test_poly_ends();
        finish_poly(1'b1);
        finish_poly(1'b0);
    endtask

    task automatic test_random_stream();
        int burst;
        while (coeffs_sent < TARGET_COEFFS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                set_width(CFG_W'($urandom_range(0, 7)));
            end
            else
            begin
                set_width(CFG_W'($urandom_range(D_MIN, D_MAX)));
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(10, 150);
            repeat (burst) send_coeff(rand_coeff());
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : byte_ready_driver
        int hold;
        hold = $urandom_range(0, MAX_IDLE);
        byte_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (byte_ch.valid && byte_ch.ready)
            begin
                hold = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
            end
            else if (hold > 0)
            begin
                hold--;
            end
            byte_ch.ready <= (rst_n === 1'b1) && (hold == 0);
        end
    end

    always @(posedge clk)
    begin : byte_checker
        byte_word_t want;
        if (rst_n === 1'b1 && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          byte_ch.packed_byte, byte_ch.last_byte));
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (byte_ch.packed_byte !== want.packed_byte)
                begin
                    report_mismatch($sformatf("byte %0d: packed_byte %02h, want %02h",
                                              bytes_checked, byte_ch.packed_byte,
                                              want.packed_byte));
                end
                if (byte_ch.last_byte !== want.last_byte)
                begin
                    report_mismatch($sformatf("byte %0d: last_byte %0b, want %0b",
                                              bytes_checked, byte_ch.last_byte,
                                              want.last_byte));
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("poly_coeff_compress_pack verification failed");
        $finish;
    end

    initial
    begin
        width_reg = CFG_RESET;
        pend_bits = '0;
        pend_cnt = 0;
        coeff_pos = 0;
        no_gaps = 1'b0;
        widths_seen = '0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        coeff_ch.valid <= 1'b0;
        coeff_ch.coefficient <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_width_sweep();
        test_poly_ends();
        test_random_stream();

        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("streamed %0d coefficients into %0d checked bytes, %0d polynomials closed",
                 coeffs_sent, bytes_checked, polys_done);
        $display("%0d of 8 width codes written, with mid-polynomial changes and end padding",
                 $countones(widths_seen));
        if (errors == 0)
        begin
            $display("poly_coeff_compress_pack verification clean");
        end
        else
        begin
            $display("poly_coeff_compress_pack verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pccp_pkg.sv
rtl/core/pccp_if.sv
rtl/core/poly_coeff_compress_pack.sv
verif/poly_coeff_compress_pack_tb.sv
